### rtl/swfs_pkg.sv
// ----------------------------------------------------------------------------
// swfs_pkg
// Shared types and constants for the SQL window function stream: function
// codes, configuration record, queue entry and divider sizing.
// ----------------------------------------------------------------------------
package swfs_pkg;

   // Partition counters wrap at this width
   localparam int CNT_W       = 48;
   // Result and key widths
   localparam int VALUE_W     = 64;
   localparam int KEY_W       = 64;
   localparam int ARG_W       = 32;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Average divider: one quotient bit per cycle
   localparam int DIV_STEPS   = VALUE_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index, taken from the word address bit
   localparam logic REG_WINDOW_FUNCTION   = 1'b0;
   localparam logic REG_ORDER_KEY_PRESENT = 1'b1;

   typedef enum logic [2:0] {
      WF_ROW_NUMBER = 3'd0,
      WF_RANK       = 3'd1,
      WF_DENSE_RANK = 3'd2,
      WF_SUM        = 3'd3,
      WF_COUNT      = 3'd4,
      WF_AVERAGE    = 3'd5,
      WF_MINIMUM    = 3'd6,
      WF_MAXIMUM    = 3'd7
   } wfn_type;

   typedef struct packed {
      wfn_type func;
      logic    order_key_present;
   } cfg_type;

   // One classified request waiting for the back end
   typedef struct packed {
      logic               is_div;    // average: divide value by divisor
      logic               res_null;
      logic [VALUE_W-1:0] value;     // final result, or running sum to divide
      logic [CNT_W-1:0]   divisor;   // nonzero value count when is_div
   } job_type;

endpackage

### rtl/swfs_if.sv
// ----------------------------------------------------------------------------
// swfs_req_if / swfs_rsp_if
// Valid/ready channels carrying a sorted row in and a window value out.
// ----------------------------------------------------------------------------
interface swfs_req_if;
   logic               valid;
   logic               ready;
   logic [63:0]        partition_key;
   logic               partition_key_null;
   logic [63:0]        order_key;
   logic               order_key_null;
   logic signed [31:0] arg_value;
   logic               arg_present;

   modport source (
      output valid, partition_key, partition_key_null, order_key,
             order_key_null, arg_value, arg_present,
      input  ready
   );
   modport sink (
      input  valid, partition_key, partition_key_null, order_key,
             order_key_null, arg_value, arg_present,
      output ready
   );
endinterface

interface swfs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] result_value;
   logic               result_null;

   modport source (
      output valid, result_value, result_null,
      input  ready
   );
   modport sink (
      input  valid, result_value, result_null,
      output ready
   );
endinterface

### rtl/sql_window_function_stream.sv
// ----------------------------------------------------------------------------
// sql_window_function_stream
// Window function over a sorted row stream: row number, rank, dense rank,
// or running sum, count, average, minimum or maximum per partition.
//
//   Channel   Direction  Handshake        Contents
//   req_ch    in         valid/ready      partition key, order key, argument
//   rsp_ch    out        valid/ready      result value, result null
//   csr_*     in         APB-style write  window_function @0, order_key_present @4
//
// The front end takes one request per cycle while the four-entry job queue
// has room; non-average results leave at one per cycle through the result
// register while rsp_ch is ready and the divider is idle. An average holds
// the back end for the 64-step restoring divider that shares one subtractor.
// Reset is synchronous; queue and back-end data are not cleared; no clearing pass.
// Either side may stall independently; the queue absorbs the difference.
// ----------------------------------------------------------------------------
module sql_window_function_stream (
   input  logic                                clock,
   input  logic                                reset,
   swfs_req_if.sink                            req_ch,
   swfs_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swfs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [swfs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [swfs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import swfs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   logic    reg_sel;
   logic    push, full, pop, empty;
   job_type push_job, head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_WINDOW_FUNCTION:   cfg_in.func = wfn_type'(csr_pwdata[2:0]);
            REG_ORDER_KEY_PRESENT: cfg_in.order_key_present = csr_pwdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // Register readback
   always_comb begin
      case (reg_sel)
         REG_WINDOW_FUNCTION:   csr_prdata = CSR_DATA_W'(cfg_ff.func);
         REG_ORDER_KEY_PRESENT: csr_prdata = CSR_DATA_W'(cfg_ff.order_key_present);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.func              <= WF_ROW_NUMBER;
         cfg_ff.order_key_present <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swfs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg_ff),
      .full     (full),
      .push     (push),
      .push_job (push_job)
   );

   swfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   swfs_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

### rtl/swfs_front.sv
// ----------------------------------------------------------------------------
// swfs_front
// Accepts one row per cycle unless the queue is full, tracks partition
// boundaries, ranks and running aggregates, and queues a classified job.
// ----------------------------------------------------------------------------
module swfs_front (
   input  logic              clock,
   input  logic              reset,
   swfs_req_if.sink          req,
   input  swfs_pkg::cfg_type cfg,
   input  logic              full,
   output logic              push,
   output swfs_pkg::job_type push_job
);
   import swfs_pkg::*;

   // Null equals null; a null key's value bits are ignored
   function automatic logic keys_equal(input logic [KEY_W-1:0] ka, input logic na,
                                       input logic [KEY_W-1:0] kb, input logic nb);
      logic eq;
      if (na || nb) begin
         eq = na && nb;
      end else begin
         eq = (ka == kb);
      end
      return eq;
   endfunction

   logic                    seen_ff;
   logic [KEY_W-1:0]        pkey_ff;
   logic                    pnull_ff;
   logic [KEY_W-1:0]        okey_ff;
   logic                    onull_ff;
   logic [CNT_W-1:0]        rows_ff, rows_in;
   logic [CNT_W-1:0]        rank_ff, rank_in;
   logic [CNT_W-1:0]        dense_ff, dense_in;
   logic [CNT_W-1:0]        vcnt_ff, vcnt_in;
   logic signed [VALUE_W-1:0] sum_ff, sum_in;
   logic signed [ARG_W-1:0] min_ff, min_in;
   logic signed [ARG_W-1:0] max_ff, max_in;
   logic                    hv_ff, hv_in;

   logic                    accept;
   logic                    same_part;
   logic                    tie;
   logic [CNT_W-1:0]        rows_base, vcnt_base;
   logic signed [VALUE_W-1:0] sum_base;
   logic signed [ARG_W-1:0] min_base, max_base;
   logic                    hv_base;
   logic signed [VALUE_W:0] sum_wide;
   logic signed [ARG_W-1:0] arg;

   assign req.ready = !full;
   assign accept    = req.valid && !full;
   assign push      = accept;
   assign arg       = req.arg_value;

   // Classify the row against the previous one
   assign same_part = seen_ff &&
                      keys_equal(pkey_ff, pnull_ff, req.partition_key, req.partition_key_null);
   assign tie       = cfg.order_key_present && same_part &&
                      keys_equal(okey_ff, onull_ff, req.order_key, req.order_key_null);

   // Restart partition state on a new partition
   assign rows_base = same_part ? rows_ff : '0;
   assign vcnt_base = same_part ? vcnt_ff : '0;
   assign sum_base  = same_part ? sum_ff  : '0;
   assign min_base  = same_part ? min_ff  : '0;
   assign max_base  = same_part ? max_ff  : '0;
   assign hv_base   = same_part ? hv_ff   : 1'b0;

   assign sum_wide  = {sum_base[VALUE_W-1], sum_base} +
                      {{(VALUE_W+1-ARG_W){arg[ARG_W-1]}}, arg};

   // Next ranks and aggregates
   always_comb begin
      rows_in = rows_base + CNT_W'(1);
      if (!same_part) begin
         rank_in  = CNT_W'(1);
         dense_in = CNT_W'(1);
      end else if (tie) begin
         rank_in  = rank_ff;
         dense_in = dense_ff;
      end else begin
         rank_in  = rows_ff + CNT_W'(1);
         dense_in = dense_ff + CNT_W'(1);
      end

      vcnt_in = vcnt_base;
      sum_in  = sum_base;
      min_in  = min_base;
      max_in  = max_base;
      hv_in   = hv_base;
      if (req.arg_present) begin
         vcnt_in = vcnt_base + CNT_W'(1);
         // Saturate the running sum at the signed limits
         if (sum_wide[VALUE_W] != sum_wide[VALUE_W-1]) begin
            sum_in = sum_wide[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                       : {1'b0, {(VALUE_W-1){1'b1}}};
         end else begin
            sum_in = sum_wide[VALUE_W-1:0];
         end
         hv_in = 1'b1;
         if (!hv_base) begin
            min_in = arg;
            max_in = arg;
         end else begin
            if (arg < min_base) min_in = arg;
            if (arg > max_base) max_in = arg;
         end
      end
   end

   // Build the job for the back end
   always_comb begin
      push_job          = '0;
      push_job.divisor  = vcnt_in;
      case (cfg.func)
         WF_ROW_NUMBER: push_job.value = VALUE_W'(rows_in);
         WF_RANK:       push_job.value = VALUE_W'(rank_in);
         WF_DENSE_RANK: push_job.value = VALUE_W'(dense_in);
         WF_SUM:        push_job.value = hv_in ? sum_in : '0;
         WF_COUNT:      push_job.value = VALUE_W'(vcnt_in);
         WF_AVERAGE: begin
            push_job.is_div = (vcnt_in != '0);
            push_job.value  = (vcnt_in != '0) ? sum_in : '0;
         end
         WF_MINIMUM: begin
            push_job.value    = hv_in ? VALUE_W'(min_in) : '0;
            push_job.res_null = !hv_in;
         end
         default: begin
            // maximum
            push_job.value    = hv_in ? VALUE_W'(max_in) : '0;
            push_job.res_null = !hv_in;
         end
      endcase
   end

   // Advance state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         pkey_ff     <= '0;
         pnull_ff    <= 1'b0;
         okey_ff     <= '0;
         onull_ff    <= 1'b0;
         rows_ff     <= '0;
         rank_ff     <= '0;
         dense_ff    <= '0;
         vcnt_ff     <= '0;
         sum_ff      <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
         hv_ff       <= 1'b0;
      end else if (accept) begin
         seen_ff     <= 1'b1;
         pkey_ff     <= req.partition_key;
         pnull_ff    <= req.partition_key_null;
         okey_ff     <= req.order_key;
         onull_ff    <= req.order_key_null;
         rows_ff     <= rows_in;
         rank_ff     <= rank_in;
         dense_ff    <= dense_in;
         vcnt_ff     <= vcnt_in;
         sum_ff      <= sum_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         hv_ff       <= hv_in;
      end
   end

endmodule

### rtl/swfs_queue.sv
// ----------------------------------------------------------------------------
// swfs_queue
// Short job queue that decouples the row front end from the result back end.
// ----------------------------------------------------------------------------
module swfs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swfs_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output swfs_pkg::job_type head,
   output logic              empty
);
   import swfs_pkg::*;

   job_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("push into full job queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("pop from empty job queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("job queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("job queue count did not advance on push");

endmodule

### rtl/swfs_back.sv
// ----------------------------------------------------------------------------
// swfs_back
// Drains the job queue into the result register; averages go through a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swfs_back (
   input  logic              clock,
   input  logic              reset,
   input  swfs_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   swfs_rsp_if.source        rsp
);
   import swfs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_null_ff, rsp_null_in;
   logic [VALUE_W-1:0] dvd_ff, dvd_in;     // dividend, shifts into quotient
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   dvsr_ff, dvsr_in;
   logic               neg_ff, neg_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic               out_free;
   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     diff;
   logic               ge;

   assign out_free         = !rsp_valid_ff || rsp.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.result_null  = rsp_null_ff;

   // One restoring divide step
   assign trial = {rem_ff, dvd_ff[VALUE_W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign ge    = (trial >= {1'b0, dvsr_ff});

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_null_in  = rsp_null_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!empty && head.is_div) begin
               // Load divider with the sum magnitude
               pop      = 1'b1;
               neg_in   = head.value[VALUE_W-1];
               dvd_in   = head.value[VALUE_W-1] ? (~head.value + 1'b1) : head.value;
               rem_in   = '0;
               dvsr_in  = head.divisor;
               step_in  = '0;
               state_in = ST_DIV;
            end else if (!empty && out_free) begin
               // Pass the finished value straight to the result register
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = head.value;
               rsp_null_in  = head.res_null;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            dvd_in  = {dvd_ff[VALUE_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hold the quotient until the result register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
               rsp_null_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_null_ff  <= rsp_null_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      dvsr_ff      <= dvsr_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dvsr_ff != '0)) else $error("divide by zero count");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dvsr_ff)) else $error("divider remainder too large");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !pop) else $error("queue popped while dividing");

endmodule
